// ----- rtl/core/grib2_section_walker_defines.svh -----
// Assertion macros shared by the section walker RTL.
`ifndef GRIB2_SECTION_WALKER_DEFINES_SVH
`define GRIB2_SECTION_WALKER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/grib2_sw_pkg.sv -----
// Constants, codes and the result record type of the GRIB2 section walker.
package grib2_sw_pkg;

    // Width of the offsets that the message length must fit in.
    localparam int OFFSET_BITS = 32;
    localparam int LIMIT_BITS  = (OFFSET_BITS >= 32) ? 32 : OFFSET_BITS;

    // Parse phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_IND  = 2'd1;
    localparam logic [1:0] PH_SEC  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Error codes of a result record.
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_BAD_SEC   = 3'd1;
    localparam logic [2:0] ERR_PREDEF_BM = 3'd2;
    localparam logic [2:0] ERR_NO_BITMAP = 3'd3;
    localparam logic [2:0] ERR_OVERRUN   = 3'd4;
    localparam logic [2:0] ERR_NO_FIELD  = 3'd5;
    localparam logic [2:0] ERR_SHORT_SEC = 3'd6;
    localparam logic [2:0] ERR_TOO_BIG   = 3'd7;

    // Section numbers and bitmap indicators with a meaning of their own.
    localparam logic [3:0] SEC_IND    = 4'd0;
    localparam logic [3:0] SEC_BITMAP = 4'd6;
    localparam logic [3:0] SEC_END    = 4'd7;
    localparam logic [7:0] SEC_MAX    = 8'd8;
    localparam logic [7:0] BM_NEW     = 8'd0;
    localparam logic [7:0] BM_REUSE   = 8'd254;
    localparam logic [7:0] BM_NONE    = 8'd255;

    // Indicator section layout, section header byte places and minimum lengths.
    localparam logic [31:0] IND_LEN_FIRST = 32'd8;
    localparam logic [31:0] IND_LEN_LAST  = 32'd15;
    localparam logic [63:0] MIN_TOTAL     = 64'd20;
    localparam logic [31:0] END_MARK_LEN  = 32'd4;
    localparam logic [31:0] HDR_LEN_BYTES = 32'd4;
    localparam logic [31:0] HDR_NUM_BYTE  = 32'd4;
    localparam logic [31:0] HDR_IND_BYTE  = 32'd5;
    localparam logic [31:0] MIN_SEC_LEN   = 32'd5;
    localparam logic [31:0] MIN_BM_LEN    = 32'd6;

    // One result record.
    typedef struct packed {
        logic [3:0]  section_number;
        logic [31:0] section_offset;
        logic [31:0] section_length;
        logic [31:0] bitmap_offset;
        logic        bitmap_reused;
        logic        field_end;
        logic        message_end;
        logic [15:0] field_index;
        logic [2:0]  error_code;
    } result_t;

endpackage

// ----- rtl/core/grib2_section_walker.sv -----
// GRIB2 section walker: one input byte per word, one record per section header.
// Path: an accepted byte passes the input register, then the result register, and
// its record is offered on m_ from the result register until it is taken.
// Throughput: one byte per cycle while the result side takes records; the single
// result register stalls the byte stage only when it holds a record not yet taken.
// Reset: aresetn low clears the parse state to idle and empties both registers.
`include "grib2_section_walker_defines.svh"

module grib2_section_walker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] start_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] section_number, [35:4] section_offset, [67:36] section_length,
    // [99:68] bitmap_offset, [115:100] field_index, [118:116] error_code,
    // [119] zero
    output logic [119:0] m_tdata,
    output logic [1:0]   m_tuser,   // [0] bitmap_reused, [1] field_end
    output logic         m_tlast    // message_end
);
    import grib2_sw_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_som_reg;

    // Walk state.
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] msg_pos_reg, msg_pos_next;
    logic [31:0] end_mark_reg, end_mark_next;
    logic [31:0] bis_reg, bis_next;
    logic [31:0] sec_len_reg, sec_len_next;
    logic [31:0] sec_start_reg, sec_start_next;
    logic [3:0]  sec_id_reg, sec_id_next;
    logic [31:0] saved_bm_reg, saved_bm_next;
    logic        saved_bm_valid_reg, saved_bm_valid_next;
    logic [15:0] fields_reg, fields_next;
    logic [63:0] total_reg, total_next;

    // Result register.
    logic    m_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_valid;

    logic proc_fire;

    // The byte stage advances when the result register is free or being taken.
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_som_reg  <= s_tuser[0];
        end
    end

    // Per-byte walk: counters, header assembly and the section checks.
    always_comb begin
        logic [7:0]  b;
        logic [31:0] pos;
        logic [31:0] k;
        logic [31:0] k_inc;
        logic [63:0] tot_shift;
        logic [31:0] low;
        logic        fin_req;
        logic [3:0]  fin_id;
        logic [31:0] fin_bmo;
        logic        fin_reused;
        logic [32:0] next_start;
        logic        fin_is7;

        b          = in_byte_reg;
        fin_req    = 1'b0;
        fin_id     = SEC_IND;
        fin_bmo    = '0;
        fin_reused = 1'b0;
        res_valid  = 1'b0;
        res_next   = '0;
        tot_shift  = '0;
        low        = '0;
        k          = '0;
        k_inc      = '0;
        next_start = '0;
        fin_is7    = 1'b0;

        // A start flag clears everything and begins the indicator section.
        if (in_som_reg) begin
            phase_next          = PH_IND;
            msg_pos_next        = '0;
            end_mark_next       = '0;
            bis_next            = '0;
            sec_len_next        = '0;
            sec_start_next      = '0;
            sec_id_next         = SEC_IND;
            saved_bm_next       = '0;
            saved_bm_valid_next = 1'b0;
            fields_next         = '0;
            total_next          = '0;
        end else begin
            phase_next          = phase_reg;
            msg_pos_next        = msg_pos_reg;
            end_mark_next       = end_mark_reg;
            bis_next            = bis_reg;
            sec_len_next        = sec_len_reg;
            sec_start_next      = sec_start_reg;
            sec_id_next         = sec_id_reg;
            saved_bm_next       = saved_bm_reg;
            saved_bm_valid_next = saved_bm_valid_reg;
            fields_next         = fields_reg;
            total_next          = total_reg;
        end
        pos = msg_pos_next;

        unique case (phase_next)
            PH_IND: begin
                msg_pos_next = pos + 32'd1;
                if (pos >= IND_LEN_FIRST) begin
                    tot_shift  = {total_next[55:0], b};
                    total_next = tot_shift;
                end
                if (pos == IND_LEN_LAST) begin
                    low                     = total_next[31:0];
                    res_valid               = 1'b1;
                    res_next.section_number = SEC_IND;
                    res_next.section_length = low;
                    res_next.field_index    = fields_next;
                    if (|total_next[63:LIMIT_BITS]) begin
                        res_next.error_code = ERR_TOO_BIG;
                        phase_next          = PH_DONE;
                    end else if (total_next <= MIN_TOTAL) begin
                        res_next.error_code = ERR_NO_FIELD;
                        phase_next          = PH_DONE;
                    end else begin
                        res_next.error_code = ERR_OK;
                        end_mark_next       = low - END_MARK_LEN;
                        phase_next          = PH_SEC;
                        bis_next            = '0;
                    end
                end
            end
            PH_SEC: begin
                msg_pos_next = pos + 32'd1;
                k            = bis_next;
                k_inc        = k + 32'd1;
                if (k == '0) begin
                    sec_start_next = pos;
                    sec_len_next   = '0;
                end
                bis_next = k_inc;
                // Error records carry the current section's place and length.
                res_next.section_offset = sec_start_next;
                res_next.section_length = sec_len_next;
                res_next.field_index    = fields_next;
                if (k < HDR_LEN_BYTES) begin
                    sec_len_next = {sec_len_next[23:0], b};
                end else if (k == HDR_NUM_BYTE) begin
                    if (b > SEC_MAX) begin
                        res_valid               = 1'b1;
                        res_next.section_number = b[3:0];
                        res_next.error_code     = ERR_BAD_SEC;
                        phase_next              = PH_DONE;
                    end else begin
                        sec_id_next = b[3:0];
                        if (sec_len_next < MIN_SEC_LEN ||
                            (b[3:0] == SEC_BITMAP && sec_len_next < MIN_BM_LEN)) begin
                            res_valid               = 1'b1;
                            res_next.section_number = b[3:0];
                            res_next.error_code     = ERR_SHORT_SEC;
                            phase_next              = PH_DONE;
                        end else begin
                            if (b[3:0] != SEC_BITMAP) begin
                                fin_req = 1'b1;
                                fin_id  = b[3:0];
                            end
                            if (k_inc == sec_len_next) begin
                                bis_next = '0;
                            end
                        end
                    end
                end else begin
                    if (k_inc == sec_len_next) begin
                        bis_next = '0;
                    end
                    // The byte after a bitmap header is its indicator.
                    if (k == HDR_IND_BYTE && sec_id_next == SEC_BITMAP) begin
                        if (b == BM_NEW) begin
                            saved_bm_next       = sec_start_next;
                            saved_bm_valid_next = 1'b1;
                            fin_req             = 1'b1;
                            fin_id              = SEC_BITMAP;
                            fin_bmo             = sec_start_next;
                        end else if (b == BM_NONE) begin
                            fin_req = 1'b1;
                            fin_id  = SEC_BITMAP;
                            fin_bmo = sec_start_next;
                        end else if (b == BM_REUSE && saved_bm_valid_next) begin
                            fin_req    = 1'b1;
                            fin_id     = SEC_BITMAP;
                            fin_bmo    = saved_bm_next;
                            fin_reused = 1'b1;
                        end else begin
                            res_valid               = 1'b1;
                            res_next.section_number = SEC_BITMAP;
                            res_next.error_code     = (b == BM_REUSE) ? ERR_NO_BITMAP
                                                                      : ERR_PREDEF_BM;
                            phase_next              = PH_DONE;
                        end
                    end
                end
            end
            default: begin
                // Idle or finished: the byte is dropped.
                msg_pos_next = msg_pos_next;
            end
        endcase

        // Close a good section header: check it against the end marker.
        if (fin_req) begin
            next_start              = {1'b0, sec_start_next} + {1'b0, sec_len_next};
            fin_is7                 = (fin_id == SEC_END);
            res_valid               = 1'b1;
            res_next.section_number = fin_id;
            if (next_start > {1'b0, end_mark_next}) begin
                res_next.error_code = ERR_OVERRUN;
                phase_next          = PH_DONE;
            end else if (next_start == {1'b0, end_mark_next} && !fin_is7) begin
                res_next.error_code = ERR_NO_FIELD;
                phase_next          = PH_DONE;
            end else begin
                res_next.error_code    = ERR_OK;
                res_next.bitmap_offset = fin_bmo;
                res_next.bitmap_reused = fin_reused;
                res_next.field_end     = fin_is7;
                if (fin_is7) begin
                    fields_next = fields_next + 16'd1;
                end
                if (next_start == {1'b0, end_mark_next}) begin
                    res_next.message_end = 1'b1;
                    phase_next           = PH_DONE;
                end
            end
        end
    end

    // State update, one byte per fire.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            msg_pos_reg        <= '0;
            end_mark_reg       <= '0;
            bis_reg            <= '0;
            sec_len_reg        <= '0;
            sec_start_reg      <= '0;
            sec_id_reg         <= SEC_IND;
            saved_bm_reg       <= '0;
            saved_bm_valid_reg <= 1'b0;
            fields_reg         <= '0;
            total_reg          <= '0;
        end else if (proc_fire) begin
            phase_reg          <= phase_next;
            msg_pos_reg        <= msg_pos_next;
            end_mark_reg       <= end_mark_next;
            bis_reg            <= bis_next;
            sec_len_reg        <= sec_len_next;
            sec_start_reg      <= sec_start_next;
            sec_id_reg         <= sec_id_next;
            saved_bm_reg       <= saved_bm_next;
            saved_bm_valid_reg <= saved_bm_valid_next;
            fields_reg         <= fields_next;
            total_reg          <= total_next;
        end
    end

    // Result register: loaded by a byte that yields a record, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_fire && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (proc_fire && res_valid) begin
            res_reg <= res_next;
        end
    end

    // Output word packing.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg.error_code, res_reg.field_index,
                       res_reg.bitmap_offset, res_reg.section_length,
                       res_reg.section_offset, res_reg.section_number};
    assign m_tuser  = {res_reg.field_end, res_reg.bitmap_reused};
    assign m_tlast  = res_reg.message_end;

    // Checks on the walk.
    `GSW_ASSERT_NOW(a_err_no_flags, m_valid_reg && res_reg.error_code != ERR_OK, !m_tlast && m_tuser == 2'b00 && res_reg.bitmap_offset == '0, "error record carries flags")
    `GSW_ASSERT_NOW(a_end_is_sec7, m_valid_reg && m_tlast, m_tuser[1] && res_reg.section_number == SEC_END, "message end without a closing section 7")
    `GSW_ASSERT_NEXT(a_err_stops, proc_fire && res_valid && res_next.error_code != ERR_OK, phase_reg == PH_DONE, "walk continues after an error")
    `GSW_ASSERT_NOW(a_ready_free, !m_valid_reg, s_tready, "input stalled with an empty result register")

endmodule
